@@ sv/tcc_pkg.sv @@
// shared types and constants of the touch coordinate calibrator
package tcc_pkg;

  // field widths
  localparam int RAW_BITS  = 12;
  localparam int BYTE_BITS = 8;
  localparam int NIB_BITS  = 4;
  localparam int RES_W     = 13;
  localparam int MODE_W    = 3;

  // scaling product and divider sizing
  localparam int PROD_W    = RAW_BITS + RES_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // configuration port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;

  // request kinds
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_POLL   = 1'b1;

  // axis_mode bits
  localparam int MODE_SWAP  = 0;
  localparam int MODE_INV_X = 1;
  localparam int MODE_INV_Y = 2;

  // register contents
  typedef struct packed {
    logic [MODE_W-1:0]   axis_mode;
    logic [RAW_BITS-1:0] raw_min_x;
    logic [RAW_BITS-1:0] raw_max_x;
    logic [RAW_BITS-1:0] raw_min_y;
    logic [RAW_BITS-1:0] raw_max_y;
    logic [RES_W-1:0]    screen_width;
    logic [RES_W-1:0]    screen_height;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_sample;
    logic prep;
    logic mul;
    logic div_step;
    logic fin;
    logic out_load;
    logic press;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic seen;
    logic out_busy;
  } ctl_stat_t;

endpackage

@@ sv/tcc_cfg.sv @@
// configuration register file with apb-style access
module tcc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tcc_pkg::DATA_W-1:0]  pwdata,
  output logic [tcc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tcc_pkg::cfg_t               cfg
);

  localparam logic [2:0] REG_AXIS_MODE     = 3'd0;
  localparam logic [2:0] REG_RAW_MIN_X     = 3'd1;
  localparam logic [2:0] REG_RAW_MAX_X     = 3'd2;
  localparam logic [2:0] REG_RAW_MIN_Y     = 3'd3;
  localparam logic [2:0] REG_RAW_MAX_Y     = 3'd4;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd5;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd6;

  logic [2:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.axis_mode     <= '0;
      cfg.raw_min_x     <= '0;
      cfg.raw_max_x     <= '1;
      cfg.raw_min_y     <= '0;
      cfg.raw_max_y     <= '1;
      cfg.screen_width  <= tcc_pkg::RES_W'(320);
      cfg.screen_height <= tcc_pkg::RES_W'(240);
    end else if (wr_en) begin
      case (reg_index)
        REG_AXIS_MODE:     cfg.axis_mode     <= pwdata[tcc_pkg::MODE_W-1:0];
        REG_RAW_MIN_X:     cfg.raw_min_x     <= pwdata[tcc_pkg::RAW_BITS-1:0];
        REG_RAW_MAX_X:     cfg.raw_max_x     <= pwdata[tcc_pkg::RAW_BITS-1:0];
        REG_RAW_MIN_Y:     cfg.raw_min_y     <= pwdata[tcc_pkg::RAW_BITS-1:0];
        REG_RAW_MAX_Y:     cfg.raw_max_y     <= pwdata[tcc_pkg::RAW_BITS-1:0];
        REG_SCREEN_WIDTH:  cfg.screen_width  <= pwdata[tcc_pkg::RES_W-1:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= pwdata[tcc_pkg::RES_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_index)
      REG_AXIS_MODE:     prdata = tcc_pkg::DATA_W'(cfg.axis_mode);
      REG_RAW_MIN_X:     prdata = tcc_pkg::DATA_W'(cfg.raw_min_x);
      REG_RAW_MAX_X:     prdata = tcc_pkg::DATA_W'(cfg.raw_max_x);
      REG_RAW_MIN_Y:     prdata = tcc_pkg::DATA_W'(cfg.raw_min_y);
      REG_RAW_MAX_Y:     prdata = tcc_pkg::DATA_W'(cfg.raw_max_y);
      REG_SCREEN_WIDTH:  prdata = tcc_pkg::DATA_W'(cfg.screen_width);
      REG_SCREEN_HEIGHT: prdata = tcc_pkg::DATA_W'(cfg.screen_height);
      default:           prdata = '0;
    endcase
  end

endmodule

@@ sv/tcc_axis.sv @@
// one calibration lane: clamp, multiply, restoring divide, saturate, invert
module tcc_axis (
  input  logic                          clk,
  input  tcc_pkg::ctl_cmd_t             cmd,
  input  logic [tcc_pkg::RAW_BITS-1:0]  v,
  input  logic [tcc_pkg::RAW_BITS-1:0]  lo,
  input  logic [tcc_pkg::RAW_BITS-1:0]  hi,
  input  logic [tcc_pkg::RES_W-1:0]     res,
  input  logic                          inv,
  output logic [tcc_pkg::RES_W-1:0]     result
);

  logic [tcc_pkg::RAW_BITS-1:0] diff;
  logic [tcc_pkg::RAW_BITS-1:0] rng;
  logic                         rng_ok;
  logic [tcc_pkg::RES_W-1:0]    res_r;
  logic                         inv_r;
  logic [tcc_pkg::PROD_W-1:0]   quo;
  logic [tcc_pkg::RAW_BITS-1:0] rem;

  logic [tcc_pkg::RAW_BITS:0]   trial;
  logic                         ge;
  logic [tcc_pkg::RES_W-1:0]    sat;
  logic [tcc_pkg::RES_W-1:0]    scaled;

  // divider step and final saturation
  always_comb begin
    trial  = {rem, quo[tcc_pkg::PROD_W-1]};
    ge     = trial >= {1'b0, rng};
    sat    = (quo > tcc_pkg::PROD_W'(res_r)) ? res_r : quo[tcc_pkg::RES_W-1:0];
    scaled = rng_ok ? sat : '0;
  end

  always_ff @(posedge clk) begin
    // clamp at the minimum and latch the range
    if (cmd.prep) begin
      diff   <= (v > lo) ? v - lo : '0;
      rng    <= hi - lo;
      rng_ok <= hi > lo;
      res_r  <= res;
      inv_r  <= inv;
    end
    // offset times resolution, then one quotient bit per cycle
    if (cmd.mul) begin
      quo <= tcc_pkg::PROD_W'(diff * res_r);
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? tcc_pkg::RAW_BITS'(trial - {1'b0, rng}) : trial[tcc_pkg::RAW_BITS-1:0];
      quo <= {quo[tcc_pkg::PROD_W-2:0], ge};
    end
    // optional inversion
    if (cmd.fin) begin
      result <= inv_r ? res_r - scaled : scaled;
    end
  end

endmodule

@@ sv/tcc_dpath.sv @@
// datapath: held sample, two calibration lanes and the result register
module tcc_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  tcc_pkg::ctl_cmd_t              cmd,
  output tcc_pkg::ctl_stat_t             stat,
  input  tcc_pkg::cfg_t                  cfg,
  input  logic [tcc_pkg::BYTE_BITS-1:0]  sample_byte_a,
  input  logic [tcc_pkg::BYTE_BITS-1:0]  sample_byte_b,
  input  logic [tcc_pkg::BYTE_BITS-1:0]  sample_byte_c,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           pressed,
  output logic [tcc_pkg::RES_W-1:0]      point_x,
  output logic [tcc_pkg::RES_W-1:0]      point_y
);

  logic [tcc_pkg::RAW_BITS-1:0] held_raw_x;
  logic [tcc_pkg::RAW_BITS-1:0] held_raw_y;
  logic                         sample_seen;
  logic                         swap;
  logic [tcc_pkg::RAW_BITS-1:0] vx;
  logic [tcc_pkg::RAW_BITS-1:0] vy;
  logic [tcc_pkg::RES_W-1:0]    cal_x;
  logic [tcc_pkg::RES_W-1:0]    cal_y;

  assign stat.seen     = sample_seen;
  assign stat.out_busy = out_valid && out_stall;

  // axis swap ahead of the lanes
  assign swap = cfg.axis_mode[tcc_pkg::MODE_SWAP];
  assign vx   = swap ? held_raw_y : held_raw_x;
  assign vy   = swap ? held_raw_x : held_raw_y;

  // unpack the three fifo bytes into the latest sample
  always_ff @(posedge clk) begin
    if (rst) begin
      held_raw_x  <= '0;
      held_raw_y  <= '0;
      sample_seen <= 1'b0;
    end else if (cmd.load_sample) begin
      held_raw_x  <= tcc_pkg::RAW_BITS'({sample_byte_a,
                                         sample_byte_b[tcc_pkg::BYTE_BITS-1 -: tcc_pkg::NIB_BITS]});
      held_raw_y  <= tcc_pkg::RAW_BITS'({sample_byte_b[tcc_pkg::NIB_BITS-1:0], sample_byte_c});
      sample_seen <= 1'b1;
    end else if (cmd.out_load) begin
      sample_seen <= 1'b0;
    end
  end

  tcc_axis u_axis_x (
    .clk    (clk),
    .cmd    (cmd),
    .v      (vx),
    .lo     (cfg.raw_min_x),
    .hi     (cfg.raw_max_x),
    .res    (cfg.screen_width),
    .inv    (cfg.axis_mode[tcc_pkg::MODE_INV_X]),
    .result (cal_x)
  );

  tcc_axis u_axis_y (
    .clk    (clk),
    .cmd    (cmd),
    .v      (vy),
    .lo     (cfg.raw_min_y),
    .hi     (cfg.raw_max_y),
    .res    (cfg.screen_height),
    .inv    (cfg.axis_mode[tcc_pkg::MODE_INV_Y]),
    .result (cal_y)
  );

  // result register, also the last reported point
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pressed   <= 1'b0;
      point_x   <= '0;
      point_y   <= '0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        pressed   <= cmd.press;
        if (cmd.press) begin
          point_x <= cal_x;
          point_y <= cal_y;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/tcc_ctrl.sv @@
// controller: takes samples and sequences a poll through prepare, multiply, divide, finish and report
module tcc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  output tcc_pkg::ctl_cmd_t  ctl,
  input  tcc_pkg::ctl_stat_t stat
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]                state;
  logic [2:0]                state_next;
  logic [tcc_pkg::CNT_W-1:0] cnt;
  logic                      press;
  logic                      accept;
  logic                      last_step;

  assign in_stall  = state != ST_IDLE;
  assign accept    = in_valid && !in_stall;
  assign last_step = cnt == tcc_pkg::CNT_W'(tcc_pkg::DIV_STEPS - 1);

  // next state and commands
  always_comb begin
    state_next      = state;
    ctl             = '0;
    ctl.press       = press;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == tcc_pkg::CMD_SAMPLE) begin
            ctl.load_sample = 1'b1;
          end else if (stat.seen) begin
            state_next = ST_PREP;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_PREP: begin
        ctl.prep   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        ctl.mul    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        if (last_step) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        ctl.fin    = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!stat.out_busy) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state, step counter and pressed flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      press <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        cnt <= last_step ? '0 : cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (accept && cmd == tcc_pkg::CMD_POLL) begin
        press <= stat.seen;
      end
    end
  end

endmodule

@@ sv/touch_coordinate_calibrator_core.sv @@
// top level of the touch coordinate calibrator
//
// Input channel (in_valid/in_stall): each request is either a fifo sample
// (cmd 0, three bytes holding two 12-bit raw coordinates) or a poll (cmd 1).
// A sample is taken, only the latest is kept, and it gives no
// result. A poll gives one result (pressed, point_x, point_y) on the output
// channel (out_valid/out_stall).
// A poll with a new sample passes through prepare, multiply, 25 restoring
// divide steps, finish and the load into the output register, both axes in
// parallel. A poll with no new sample reports released and the last point.
// Throughput: one sample per cycle while no poll is in work; a new poll is
// taken only after the last one is loaded into the output register.
// The input is stalled while a poll is in work. A result waiting in the
// output register does not block new samples, but a finished poll waits
// until the receiver takes the previous result; a stalled result holds.
// Reset (rst, synchronous) clears the held sample, the reported point and
// restores the register defaults. The user must write registers over the apb
// port only while the block is idle; the block itself does not enforce this.
module touch_coordinate_calibrator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tcc_pkg::ADDR_W-1:0]     paddr,
  input  logic [tcc_pkg::DATA_W-1:0]     pwdata,
  output logic [tcc_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           cmd,
  input  logic [tcc_pkg::BYTE_BITS-1:0]  sample_byte_a,
  input  logic [tcc_pkg::BYTE_BITS-1:0]  sample_byte_b,
  input  logic [tcc_pkg::BYTE_BITS-1:0]  sample_byte_c,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           pressed,
  output logic [tcc_pkg::RES_W-1:0]      point_x,
  output logic [tcc_pkg::RES_W-1:0]      point_y
);

  tcc_pkg::cfg_t      cfg;
  tcc_pkg::ctl_cmd_t  ctl;
  tcc_pkg::ctl_stat_t stat;

  tcc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .ctl      (ctl),
    .stat     (stat)
  );

  tcc_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (ctl),
    .stat          (stat),
    .cfg           (cfg),
    .sample_byte_a (sample_byte_a),
    .sample_byte_b (sample_byte_b),
    .sample_byte_c (sample_byte_c),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pressed       (pressed),
    .point_x       (point_x),
    .point_y       (point_y)
  );

endmodule

@@ sv/tcc_checker.sv @@
// port-level checks of the calibrator, bound to the top level
module tcc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      cmd,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      pressed,
  input logic [tcc_pkg::RES_W-1:0] point_x,
  input logic [tcc_pkg::RES_W-1:0] point_y
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(pressed) && $stable(point_x) && $stable(point_y))
    else $error("result changed while stalled");

  // a sample request leaves the block ready for the next request
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd == tcc_pkg::CMD_SAMPLE |=> !in_stall)
    else $error("sample request blocked the input");

  // a poll request stalls the input in the following cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd == tcc_pkg::CMD_POLL |=> in_stall)
    else $error("poll request did not hold the input");

endmodule

bind touch_coordinate_calibrator_core tcc_checker u_tcc_checker (.*);

@@ test/touch_coordinate_calibrator_core_tb.sv @@
// self-checking testbench for the touch coordinate calibrator core
module touch_coordinate_calibrator_core_tb;
  import tcc_pkg::*;

  // register indexes on the apb port
  localparam int REG_AXIS_MODE     = 0;
  localparam int REG_RAW_MIN_X     = 1;
  localparam int REG_RAW_MAX_X     = 2;
  localparam int REG_RAW_MIN_Y     = 3;
  localparam int REG_RAW_MAX_Y     = 4;
  localparam int REG_SCREEN_WIDTH  = 5;
  localparam int REG_SCREEN_HEIGHT = 6;

  // run shape
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_LIMIT    = 4000;
  localparam int MAX_PRINTS    = 40;
  localparam int NUM_PHASES    = 10;
  localparam int PHASE_ITEMS   = 193;

  typedef struct {
    logic                 kind;
    logic [BYTE_BITS-1:0] a;
    logic [BYTE_BITS-1:0] b;
    logic [BYTE_BITS-1:0] c;
    bit                   hold;
  } touch_req_t;

  typedef struct {
    logic             pressed;
    logic [RES_W-1:0] x;
    logic [RES_W-1:0] y;
  } touch_report_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 cmd = CMD_SAMPLE;
  logic [BYTE_BITS-1:0] sample_byte_a = '0, sample_byte_b = '0, sample_byte_c = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 pressed;
  logic [RES_W-1:0]     point_x, point_y;

  touch_coordinate_calibrator_core dut (.*);

  // predictor state and calibration copy
  touch_req_t          pending_reqs[$];
  touch_report_t       awaited_reports[$];
  touch_req_t          cur_req;
  cfg_t                cal_cfg;
  logic [RAW_BITS-1:0] held_x, held_y;
  bit                  fresh_sample;
  logic [RES_W-1:0]    last_x, last_y;

  int  errors, pushed_count, accepted_count, settings_count;
  int  n_samples, n_polls, n_pressed, n_released;
  int  gap_left, stall_left;
  bit  idle_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 60);
  endfunction

  // clamp at min, scale, saturate at res, optionally mirror
  function automatic logic [RES_W-1:0] scale_coord(logic [RAW_BITS-1:0] v,
      logic [RAW_BITS-1:0] lo, logic [RAW_BITS-1:0] hi, logic [RES_W-1:0] res, bit flip);
    int unsigned vv, l, h, r, q, s;
    vv = v;
    l  = lo;
    h  = hi;
    r  = res;
    s  = 0;
    if (vv < l) vv = l;
    if (h > l) begin
      q = ((vv - l) * r) / (h - l);
      s = (q > r) ? r : q;
    end
    if (flip) s = r - s;
    return RES_W'(s);
  endfunction

  // update the predicted state for one accepted request
  function automatic void track_request(touch_req_t req);
    touch_report_t       rep;
    logic [RAW_BITS-1:0] vx, vy;
    bit                  swap;
    if (req.kind == CMD_SAMPLE) begin
      held_x = {req.a, req.b[7:4]};
      held_y = {req.b[3:0], req.c};
      fresh_sample = 1'b1;
      n_samples++;
    end else begin
      if (fresh_sample) begin
        swap   = cal_cfg.axis_mode[MODE_SWAP];
        vx     = swap ? held_y : held_x;
        vy     = swap ? held_x : held_y;
        last_x = scale_coord(vx, cal_cfg.raw_min_x, cal_cfg.raw_max_x,
                             cal_cfg.screen_width, cal_cfg.axis_mode[MODE_INV_X]);
        last_y = scale_coord(vy, cal_cfg.raw_min_y, cal_cfg.raw_max_y,
                             cal_cfg.screen_height, cal_cfg.axis_mode[MODE_INV_Y]);
        fresh_sample = 1'b0;
        rep.pressed = 1'b1;
      end else begin
        rep.pressed = 1'b0;
      end
      rep.x = last_x;
      rep.y = last_y;
      awaited_reports.push_back(rep);
      n_polls++;
    end
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic void queue_sample(logic [RAW_BITS-1:0] x, logic [RAW_BITS-1:0] y);
    touch_req_t r;
    r.kind = CMD_SAMPLE;
    r.a    = x[11:4];
    r.b    = {x[3:0], y[11:8]};
    r.c    = y[7:0];
    r.hold = 1'b0;
    pending_reqs.push_back(r);
    pushed_count++;
  endfunction

  // poll bytes are don't-care, so they are random
  function automatic void queue_poll(bit hold);
    touch_req_t r;
    r.kind = CMD_POLL;
    r.a    = BYTE_BITS'($urandom());
    r.b    = BYTE_BITS'($urandom());
    r.c    = BYTE_BITS'($urandom());
    r.hold = hold;
    pending_reqs.push_back(r);
    pushed_count++;
  endfunction

  // raw reading biased toward the calibration edges
  function automatic logic [RAW_BITS-1:0] pick_raw();
    logic [RAW_BITS-1:0] lo, hi;
    if ($urandom_range(0, 1) == 1) begin
      lo = cal_cfg.raw_min_x;
      hi = cal_cfg.raw_max_x;
    end else begin
      lo = cal_cfg.raw_min_y;
      hi = cal_cfg.raw_max_y;
    end
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return lo;
      3: return hi;
      4: return lo - 1'b1;
      5: return hi + 1'b1;
      default: return RAW_BITS'($urandom());
    endcase
  endfunction

  // mostly sample-then-poll sequences, plus bare polls and stray samples
  function automatic void fill_random(int n_items);
    int made, r, k;
    made = 0;
    while (made < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
        repeat (k) queue_sample(pick_raw(), pick_raw());
        queue_poll($urandom_range(0, 49) == 0);
        made += k + 1;
      end else if (r < 90) begin
        queue_poll(1'b0);
        made++;
      end else begin
        queue_sample(pick_raw(), pick_raw());
        made++;
      end
    end
  endfunction

  function automatic int unsigned pick_res();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return 4096;
      3: return 8191;
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  // apb write: setup cycle, then access cycle
  task automatic write_reg(int idx, int unsigned value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_AXIS_MODE:     cal_cfg.axis_mode     = value[MODE_W-1:0];
      REG_RAW_MIN_X:     cal_cfg.raw_min_x     = value[RAW_BITS-1:0];
      REG_RAW_MAX_X:     cal_cfg.raw_max_x     = value[RAW_BITS-1:0];
      REG_RAW_MIN_Y:     cal_cfg.raw_min_y     = value[RAW_BITS-1:0];
      REG_RAW_MAX_Y:     cal_cfg.raw_max_y     = value[RAW_BITS-1:0];
      REG_SCREEN_WIDTH:  cal_cfg.screen_width  = value[RES_W-1:0];
      REG_SCREEN_HEIGHT: cal_cfg.screen_height = value[RES_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(int unsigned mode, int unsigned min_x, int unsigned max_x,
      int unsigned min_y, int unsigned max_y, int unsigned width, int unsigned height);
    write_reg(REG_AXIS_MODE, mode);
    write_reg(REG_RAW_MIN_X, min_x);
    write_reg(REG_RAW_MAX_X, max_x);
    write_reg(REG_RAW_MIN_Y, min_y);
    write_reg(REG_RAW_MAX_Y, max_y);
    write_reg(REG_SCREEN_WIDTH, width);
    write_reg(REG_SCREEN_HEIGHT, height);
    settings_count++;
  endtask

  // ordered range most of the time, anything otherwise
  task automatic apply_random_setting();
    int unsigned ax, bx, ay, by;
    ax = $urandom_range(0, 4095);
    bx = $urandom_range(0, 4095);
    ay = $urandom_range(0, 4095);
    by = $urandom_range(0, 4095);
    if ($urandom_range(0, 9) < 7) begin
      if (ax > bx) {ax, bx} = {bx, ax};
      if (ay > by) {ay, by} = {by, ay};
    end
    apply_setting($urandom_range(0, 7), ax, bx, ay, by, pick_res(), pick_res());
  endtask

  // all requests taken, all results seen, then let the block settle
  task automatic wait_drained();
    while (accepted_count != pushed_count || awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin : request_drive
    touch_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        track_request(cur_req);
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].hold && awaited_reports.size() != 0)) begin
          req = pending_reqs.pop_front();
          cur_req = req;
          in_valid      <= 1'b1;
          cmd           <= req.kind;
          sample_byte_a <= req.a;
          sample_byte_b <= req.b;
          sample_byte_c <= req.c;
          gap_left = idle_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : result_check
    touch_report_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_reports.size() == 0) begin
          report_mismatch($sformatf("unexpected result pressed=%0b x=%0d y=%0d",
                                    pressed, point_x, point_y));
        end else begin
          want = awaited_reports.pop_front();
          if (pressed !== want.pressed)
            report_mismatch($sformatf("pressed %0b, want %0b", pressed, want.pressed));
          if (point_x !== want.x)
            report_mismatch($sformatf("point_x %0d, want %0d", point_x, want.x));
          if (point_y !== want.y)
            report_mismatch($sformatf("point_y %0d, want %0d", point_y, want.y));
          if (want.pressed) n_pressed++;
          else n_released++;
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        stall_left = pick_gap();
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pwrite && pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // stimulus and phase sequencing
  initial begin : stimulus
    int p;
    cal_cfg.axis_mode     = '0;
    cal_cfg.raw_min_x     = '0;
    cal_cfg.raw_max_x     = 12'd4095;
    cal_cfg.raw_min_y     = '0;
    cal_cfg.raw_max_y     = 12'd4095;
    cal_cfg.screen_width  = 13'd320;
    cal_cfg.screen_height = 13'd240;
    held_x       = '0;
    held_y       = '0;
    fresh_sample = 1'b0;
    last_x       = '0;
    last_y       = '0;
    idle_on      = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: released poll, unpacking, extremes, last sample wins
    queue_poll(1'b0);
    queue_sample(12'h000, 12'h000);
    queue_poll(1'b0);
    queue_sample(12'hFFF, 12'hFFF);
    queue_poll(1'b0);
    queue_poll(1'b0);
    queue_sample(12'h800, 12'h400);
    queue_sample(12'hABC, 12'h123);
    queue_poll(1'b0);
    queue_sample(12'h5A5, 12'hA5A);
    queue_poll(1'b1);
    wait_drained();

    // swap plus both inversions, zero and negative range, zero and max resolution
    apply_setting(7, 100, 100, 3000, 1000, 0, 8191);
    queue_sample(12'h064, 12'hBB8);
    queue_poll(1'b0);
    queue_sample(12'hFFF, 12'h000);
    queue_poll(1'b0);
    queue_poll(1'b0);
    wait_drained();

    // clamping below min and saturation beyond max
    apply_setting(6, 1000, 2000, 0, 1, 4096, 4096);
    queue_sample(12'h000, 12'hFFF);
    queue_poll(1'b0);
    queue_sample(12'hFFF, 12'h001);
    queue_poll(1'b0);
    queue_sample(12'd1500, 12'h000);
    queue_poll(1'b0);
    wait_drained();

    // random phases, some without any idling
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: apply_setting(0, 0, 4095, 0, 4095, 4096, 4096);
        1: apply_setting(1, 200, 3900, 300, 3800, 320, 240);
        2: apply_setting(2, 0, 4095, 4095, 4095, 0, 8191);
        3: apply_setting(4, 1000, 1001, 2047, 2048, 8191, 1);
        4: apply_setting(3, 4095, 4095, 0, 4095, 1, 4096);
        default: apply_random_setting();
      endcase
      idle_on = (p % 3 != 1);
      fill_random(PHASE_ITEMS);
      wait_drained();
    end

    $display("run covered %0d samples and %0d polls (%0d pressed, %0d released)",
             n_samples, n_polls, n_pressed, n_released);
    $display("across %0d calibration settings plus reset defaults, %0d mismatches",
             settings_count, errors);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
